// ===== rtl/mrsp_pkg.sv =====
// ----------------------------------------------------------------------------
// MIDI running-status parser package
// Event codes, status byte constants and defaults shared by the parser.
// ----------------------------------------------------------------------------
package mrsp_pkg;

    localparam int SYSEX_BYTES_DEF = 8;

    localparam logic [7:0] BYTE_SYSEX_START = 8'hF0;
    localparam logic [7:0] BYTE_SYSEX_END   = 8'hF7;
    localparam logic [7:0] BYTE_RT_FIRST    = 8'hF8;
    localparam logic [7:0] BYTE_RT_START    = 8'hFA;
    localparam logic [7:0] BYTE_RT_CONT     = 8'hFB;
    localparam logic [7:0] BYTE_RT_STOP     = 8'hFC;
    localparam logic [7:0] BYTE_RT_RESET    = 8'hFF;

    localparam logic [6:0] SX_ID_NON_RT     = 7'h7E;
    localparam logic [6:0] SX_ID_RT         = 7'h7F;
    localparam logic [6:0] SX_DEV_ALL       = 7'h7F;
    localparam logic [6:0] SX_DEV_ZERO      = 7'h00;
    localparam logic [6:0] SX_SUB_GM        = 7'h09;
    localparam logic [6:0] SX_SUB_DEV_CTRL  = 7'h04;
    localparam logic [6:0] SX_GM_ON         = 7'h01;
    localparam logic [6:0] SX_GM_OFF        = 7'h02;
    localparam logic [6:0] SX_MASTER_VOL    = 7'h01;

    localparam logic [7:0] SX_LEN_GM        = 8'd5;
    localparam logic [7:0] SX_LEN_MVOL      = 8'd7;
    localparam logic [7:0] SX_COUNT_MAX     = 8'd255;

    localparam logic [3:0] KIND_NOTE_OFF    = 4'h8;
    localparam logic [3:0] KIND_NOTE_ON     = 4'h9;
    localparam logic [3:0] KIND_POLY_PRESS  = 4'hA;
    localparam logic [3:0] KIND_CTRL        = 4'hB;
    localparam logic [3:0] KIND_PROG        = 4'hC;
    localparam logic [3:0] KIND_CHAN_PRESS  = 4'hD;
    localparam logic [3:0] KIND_BEND        = 4'hE;

    typedef enum logic [3:0] {
        EV_NOTE_ON    = 4'd0,
        EV_NOTE_OFF   = 4'd1,
        EV_CTRL       = 4'd2,
        EV_PROG       = 4'd3,
        EV_PRESS      = 4'd4,
        EV_BEND       = 4'd5,
        EV_RESET      = 4'd6,
        EV_STOP       = 4'd7,
        EV_START      = 4'd8,
        EV_CONT       = 4'd9,
        EV_GM_ON      = 4'd10,
        EV_GM_OFF     = 4'd11,
        EV_MASTER_VOL = 4'd12
    } t_event;

    typedef struct packed {
        t_event      event_res;
        logic [3:0]  channel;
        logic [6:0]  key_or_controller;
        logic [13:0] value;
    } t_result;

endpackage

// ===== rtl/midi_running_status_parser.sv =====
// A result is registered in the output word, or in the skid if that is held.
// Throughput: one byte per cycle while o_stall is low; the per-byte decode
// sits between the input handshake and the result register, backed by a
// one-entry skid register. Input stall rises only while the skid register
// holds a word. Reset: running status, pending byte and SysEx state clear, GM
// enabled set, both output registers empty; the SysEx buffer is not cleared.
// ----------------------------------------------------------------------------
// MIDI running-status parser
// Decodes a raw MIDI byte stream into channel, real-time and SysEx events.
// ----------------------------------------------------------------------------
module midi_running_status_parser #(
    parameter int SYSEX_BYTES = mrsp_pkg::SYSEX_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_event_res,
    output logic [3:0]  o_channel,
    output logic [6:0]  o_key_or_controller,
    output logic [13:0] o_value
);

    localparam int IDX_W = (SYSEX_BYTES > 1) ? $clog2(SYSEX_BYTES) : 1;

    logic [7:0] r_rs, n_rs;
    logic       r_have, n_have;
    logic [6:0] r_first, n_first;
    logic [7:0] r_sx_count, n_sx_count;
    logic       r_gm, n_gm;
    logic [6:0] r_sx_store [SYSEX_BYTES];

    logic                r_out_valid, r_skid_valid;
    mrsp_pkg::t_result   r_out, r_skid;

    logic                in_accept, out_take;
    logic                res_valid;
    mrsp_pkg::t_result   res;
    logic                sx_wr;
    logic [7:0]          sx_wr_full;
    logic [IDX_W-1:0]    sx_wr_idx;
    logic [3:0]          kind, chan;
    logic                done;
    logic                dev_ok;

    assign in_accept  = i_valid && !o_stall;
    assign out_take   = r_out_valid && !i_stall;
    assign o_stall    = r_skid_valid;
    assign kind       = r_rs[7:4];
    assign chan       = r_rs[3:0];
    assign sx_wr_full = r_sx_count - 8'd1;
    assign sx_wr_idx  = sx_wr_full[IDX_W-1:0];
    assign dev_ok     = (r_sx_store[1] == mrsp_pkg::SX_DEV_ALL) ||
                        (r_sx_store[1] == mrsp_pkg::SX_DEV_ZERO);

    always_comb begin
        n_rs       = r_rs;
        n_have     = r_have;
        n_first    = r_first;
        n_sx_count = r_sx_count;
        n_gm       = r_gm;
        res_valid  = 1'b0;
        res        = '{event_res: mrsp_pkg::EV_NOTE_ON, channel: 4'd0,
                       key_or_controller: 7'd0, value: 14'd0};
        sx_wr      = 1'b0;
        done       = 1'b0;
        if (i_data_byte >= mrsp_pkg::BYTE_RT_FIRST) begin
            unique case (i_data_byte)
                mrsp_pkg::BYTE_RT_RESET: begin
                    n_rs = 8'd0; n_have = 1'b0; n_first = 7'd0;
                    n_sx_count = 8'd0; n_gm = 1'b1;
                    res_valid = 1'b1; res.event_res = mrsp_pkg::EV_RESET;
                end
                mrsp_pkg::BYTE_RT_STOP: begin
                    res_valid = 1'b1; res.event_res = mrsp_pkg::EV_STOP;
                end
                mrsp_pkg::BYTE_RT_START: begin
                    res_valid = 1'b1; res.event_res = mrsp_pkg::EV_START;
                end
                mrsp_pkg::BYTE_RT_CONT: begin
                    res_valid = 1'b1; res.event_res = mrsp_pkg::EV_CONT;
                end
                default: ;
            endcase
        end else begin
            if (r_sx_count != 8'd0) begin
                if (i_data_byte == mrsp_pkg::BYTE_SYSEX_END) begin
                    done       = 1'b1;
                    n_sx_count = 8'd0;
                    if (dev_ok && r_sx_count == mrsp_pkg::SX_LEN_GM &&
                        r_sx_store[0] == mrsp_pkg::SX_ID_NON_RT &&
                        r_sx_store[2] == mrsp_pkg::SX_SUB_GM) begin
                        if (r_sx_store[3] == mrsp_pkg::SX_GM_ON) begin
                            n_rs = 8'd0; n_have = 1'b0; n_first = 7'd0; n_gm = 1'b1;
                            res_valid = 1'b1; res.event_res = mrsp_pkg::EV_GM_ON;
                        end else if (r_sx_store[3] == mrsp_pkg::SX_GM_OFF) begin
                            n_gm = 1'b0;
                            res_valid = 1'b1; res.event_res = mrsp_pkg::EV_GM_OFF;
                        end
                    end else if (dev_ok && r_sx_count == mrsp_pkg::SX_LEN_MVOL &&
                                 r_sx_store[0] == mrsp_pkg::SX_ID_RT &&
                                 r_sx_store[2] == mrsp_pkg::SX_SUB_DEV_CTRL &&
                                 r_sx_store[3] == mrsp_pkg::SX_MASTER_VOL) begin
                        res_valid = 1'b1;
                        res.event_res = mrsp_pkg::EV_MASTER_VOL;
                        res.value = {7'd0, r_sx_store[5]};
                    end
                end else if (!i_data_byte[7]) begin
                    done  = 1'b1;
                    sx_wr = (r_sx_count <= 8'(SYSEX_BYTES));
                    if (r_sx_count != mrsp_pkg::SX_COUNT_MAX) begin
                        n_sx_count = r_sx_count + 8'd1;
                    end
                end else begin
                    n_sx_count = 8'd0;
                end
            end
            if (!done) begin
                if (i_data_byte[7]) begin
                    n_have = 1'b0;
                    n_rs   = (i_data_byte < mrsp_pkg::BYTE_SYSEX_START) ? i_data_byte : 8'd0;
                    if (i_data_byte == mrsp_pkg::BYTE_SYSEX_START) begin
                        n_sx_count = 8'd1;
                    end
                end else if (r_rs != 8'd0) begin
                    res.channel = chan;
                    if (kind == mrsp_pkg::KIND_PROG) begin
                        res_valid = 1'b1;
                        res.event_res = mrsp_pkg::EV_PROG;
                        res.key_or_controller = i_data_byte[6:0];
                    end else if (kind == mrsp_pkg::KIND_CHAN_PRESS) begin
                        res_valid = 1'b1;
                        res.event_res = mrsp_pkg::EV_PRESS;
                        res.value = {7'd0, i_data_byte[6:0]};
                    end else if (!r_have) begin
                        n_first = i_data_byte[6:0];
                        n_have  = 1'b1;
                    end else begin
                        n_have = 1'b0;
                        res.key_or_controller = r_first;
                        res.value = {7'd0, i_data_byte[6:0]};
                        unique case (kind)
                            mrsp_pkg::KIND_NOTE_ON: begin
                                if (i_data_byte[6:0] == 7'd0) begin
                                    res_valid = 1'b1;
                                    res.event_res = mrsp_pkg::EV_NOTE_OFF;
                                end else begin
                                    res_valid = r_gm;
                                    res.event_res = mrsp_pkg::EV_NOTE_ON;
                                end
                            end
                            mrsp_pkg::KIND_NOTE_OFF: begin
                                res_valid = 1'b1;
                                res.event_res = mrsp_pkg::EV_NOTE_OFF;
                            end
                            mrsp_pkg::KIND_CTRL: begin
                                res_valid = 1'b1;
                                res.event_res = mrsp_pkg::EV_CTRL;
                            end
                            mrsp_pkg::KIND_BEND: begin
                                res_valid = 1'b1;
                                res.event_res = mrsp_pkg::EV_BEND;
                                res.key_or_controller = 7'd0;
                                res.value = {i_data_byte[6:0], r_first};
                            end
                            default: ;
                        endcase
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rs       <= 8'd0;
            r_have     <= 1'b0;
            r_first    <= 7'd0;
            r_sx_count <= 8'd0;
            r_gm       <= 1'b1;
        end else if (in_accept) begin
            r_rs       <= n_rs;
            r_have     <= n_have;
            r_first    <= n_first;
            r_sx_count <= n_sx_count;
            r_gm       <= n_gm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && sx_wr) begin
            r_sx_store[sx_wr_idx] <= i_data_byte[6:0];
        end
    end

    // output word register plus skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (in_accept && res_valid) begin
            if (r_out_valid && !out_take) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (in_accept && res_valid) begin
            if (r_out_valid && !out_take) begin
                r_skid <= res;
            end else begin
                r_out <= res;
            end
        end
    end

    assign o_valid             = r_out_valid;
    assign o_event_res         = r_out.event_res;
    assign o_channel           = r_out.channel;
    assign o_key_or_controller = r_out.key_or_controller;
    assign o_value             = r_out.value;

    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word held without output word");

    a_sysex_no_rs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sx_count != 8'd0) |-> (r_rs == 8'd0))
        else $error("running status set inside SysEx");

    a_pending_needs_rs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_have |-> (r_rs != 8'd0))
        else $error("pending data byte without running status");

    a_sys_event_no_chan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_event_res >= mrsp_pkg::EV_RESET)) |-> (o_channel == 4'd0))
        else $error("system event carries a channel");

endmodule

// ===== test/midi_running_status_parser_checker.sv =====
// ----------------------------------------------------------------------------
// MIDI running-status parser checker
// Watches both word channels of the parser, decodes every accepted byte with
// its own parser state and compares each result word field by field against
// the oldest predicted event. Reports the mismatch count and the number of
// events still awaited.
// ----------------------------------------------------------------------------
module midi_running_status_parser_checker #(
    parameter int SYSEX_BYTES = mrsp_pkg::SYSEX_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_word_valid,
    input  logic        i_word_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_event_valid,
    input  logic        i_event_stall,
    input  logic [3:0]  i_event_res,
    input  logic [3:0]  i_channel,
    input  logic [6:0]  i_key_or_controller,
    input  logic [13:0] i_value,
    output int          o_mismatch_count,
    output int          o_pending
);

    logic [7:0]        run_status;
    logic              first_pending;
    logic [6:0]        first_byte;
    logic [7:0]        sx_count;
    logic [6:0]        sx_store [SYSEX_BYTES];
    logic              gm_on;
    mrsp_pkg::t_result expected_events [$];

    task automatic report_mismatch(input string what, input logic [13:0] want,
                                   input logic [13:0] got);
        o_mismatch_count++;
        $display("mismatch @%0t: %s expected %0d got %0d", $time, what, want, got);
    endtask

    task automatic clear_parser();
        run_status    = 8'h00;
        first_pending = 1'b0;
        first_byte    = 7'd0;
        sx_count      = 8'd0;
        gm_on         = 1'b1;
    endtask

    function automatic mrsp_pkg::t_result make_event(mrsp_pkg::t_event ev, logic [3:0] ch,
                                                     logic [6:0] key, logic [13:0] val);
        mrsp_pkg::t_result r;
        r.event_res         = ev;
        r.channel           = ch;
        r.key_or_controller = key;
        r.value             = val;
        return r;
    endfunction

    task automatic decode_midi_byte(input logic [7:0] b, output bit produced,
                                    output mrsp_pkg::t_result res);
        logic [3:0] kind;
        logic [3:0] chan;
        kind     = run_status[7:4];
        chan     = run_status[3:0];
        produced = 1'b0;
        res      = '0;
        if (b >= mrsp_pkg::BYTE_RT_FIRST) begin
            produced = 1'b1;
            case (b)
                mrsp_pkg::BYTE_RT_RESET: begin
                    clear_parser();
                    res = make_event(mrsp_pkg::EV_RESET, 4'd0, 7'd0, 14'd0);
                end
                mrsp_pkg::BYTE_RT_STOP:
                    res = make_event(mrsp_pkg::EV_STOP, 4'd0, 7'd0, 14'd0);
                mrsp_pkg::BYTE_RT_START:
                    res = make_event(mrsp_pkg::EV_START, 4'd0, 7'd0, 14'd0);
                mrsp_pkg::BYTE_RT_CONT:
                    res = make_event(mrsp_pkg::EV_CONT, 4'd0, 7'd0, 14'd0);
                default: produced = 1'b0;
            endcase
        end else if (sx_count != 8'd0 && b == mrsp_pkg::BYTE_SYSEX_END) begin
            if (sx_store[1] == mrsp_pkg::SX_DEV_ALL ||
                sx_store[1] == mrsp_pkg::SX_DEV_ZERO) begin
                if (sx_count == mrsp_pkg::SX_LEN_GM && sx_store[0] == mrsp_pkg::SX_ID_NON_RT &&
                    sx_store[2] == mrsp_pkg::SX_SUB_GM) begin
                    if (sx_store[3] == mrsp_pkg::SX_GM_ON) begin
                        clear_parser();
                        produced = 1'b1;
                        res = make_event(mrsp_pkg::EV_GM_ON, 4'd0, 7'd0, 14'd0);
                    end else if (sx_store[3] == mrsp_pkg::SX_GM_OFF) begin
                        gm_on = 1'b0;
                        produced = 1'b1;
                        res = make_event(mrsp_pkg::EV_GM_OFF, 4'd0, 7'd0, 14'd0);
                    end
                end else if (sx_count == mrsp_pkg::SX_LEN_MVOL &&
                             sx_store[0] == mrsp_pkg::SX_ID_RT &&
                             sx_store[2] == mrsp_pkg::SX_SUB_DEV_CTRL &&
                             sx_store[3] == mrsp_pkg::SX_MASTER_VOL) begin
                    produced = 1'b1;
                    res = make_event(mrsp_pkg::EV_MASTER_VOL, 4'd0, 7'd0,
                                     {7'd0, sx_store[5]});
                end
            end
            sx_count = 8'd0;
        end else if (sx_count != 8'd0 && !b[7]) begin
            if (sx_count <= SYSEX_BYTES) begin
                sx_store[sx_count - 8'd1] = b[6:0];
            end
            if (sx_count != mrsp_pkg::SX_COUNT_MAX) begin
                sx_count++;
            end
        end else if (b[7]) begin
            // status byte, also aborts a SysEx in progress
            first_pending = 1'b0;
            run_status    = (b < mrsp_pkg::BYTE_SYSEX_START) ? b : 8'h00;
            sx_count      = (b == mrsp_pkg::BYTE_SYSEX_START) ? 8'd1 : 8'd0;
        end else if (run_status != 8'h00) begin
            case (kind)
                mrsp_pkg::KIND_PROG: begin
                    produced = 1'b1;
                    res = make_event(mrsp_pkg::EV_PROG, chan, b[6:0], 14'd0);
                end
                mrsp_pkg::KIND_CHAN_PRESS: begin
                    produced = 1'b1;
                    res = make_event(mrsp_pkg::EV_PRESS, chan, 7'd0, {7'd0, b[6:0]});
                end
                default: begin
                    if (!first_pending) begin
                        first_byte    = b[6:0];
                        first_pending = 1'b1;
                    end else begin
                        first_pending = 1'b0;
                        produced      = 1'b1;
                        case (kind)
                            mrsp_pkg::KIND_NOTE_ON: begin
                                if (b == 8'h00) begin
                                    res = make_event(mrsp_pkg::EV_NOTE_OFF, chan, first_byte,
                                                     14'd0);
                                end else if (gm_on) begin
                                    res = make_event(mrsp_pkg::EV_NOTE_ON, chan, first_byte,
                                                     {7'd0, b[6:0]});
                                end else begin
                                    produced = 1'b0;
                                end
                            end
                            mrsp_pkg::KIND_NOTE_OFF: begin
                                res = make_event(mrsp_pkg::EV_NOTE_OFF, chan, first_byte,
                                                 {7'd0, b[6:0]});
                            end
                            mrsp_pkg::KIND_CTRL: begin
                                res = make_event(mrsp_pkg::EV_CTRL, chan, first_byte,
                                                 {7'd0, b[6:0]});
                            end
                            mrsp_pkg::KIND_BEND: begin
                                res = make_event(mrsp_pkg::EV_BEND, chan, 7'd0,
                                                 {b[6:0], first_byte});
                            end
                            default: produced = 1'b0;
                        endcase
                    end
                end
            endcase
        end
    endtask

    always @(posedge i_clk) begin
        mrsp_pkg::t_result want;
        mrsp_pkg::t_result predicted;
        bit                produced;
        if (!i_rst_n) begin
            clear_parser();
            expected_events.delete();
        end else begin
            if (i_event_valid && !i_event_stall) begin
                if (expected_events.size() == 0) begin
                    report_mismatch("event with none awaited, event_res", 14'd0,
                                    {10'd0, i_event_res});
                end else begin
                    want = expected_events.pop_front();
                    if (i_event_res !== want.event_res) begin
                        report_mismatch("event_res", {10'd0, want.event_res},
                                        {10'd0, i_event_res});
                    end
                    if (i_channel !== want.channel) begin
                        report_mismatch("channel", {10'd0, want.channel}, {10'd0, i_channel});
                    end
                    if (i_key_or_controller !== want.key_or_controller) begin
                        report_mismatch("key_or_controller", {7'd0, want.key_or_controller},
                                        {7'd0, i_key_or_controller});
                    end
                    if (i_value !== want.value) begin
                        report_mismatch("value", want.value, i_value);
                    end
                end
            end
            if (i_word_valid && !i_word_stall) begin
                decode_midi_byte(i_data_byte, produced, predicted);
                if (produced) begin
                    expected_events.push_back(predicted);
                end
            end
        end
        o_pending <= expected_events.size();
    end

endmodule

// ===== test/midi_running_status_parser_test.sv =====
// ----------------------------------------------------------------------------
// MIDI running-status parser testbench
// Feeds directed and random MIDI byte streams (channel messages with and
// without running status, GM and master volume SysEx, real-time bytes, noise)
// with random input idle and output stall; a checker predicts and compares.
// ----------------------------------------------------------------------------
module midi_running_status_parser_test;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_data_byte;
    logic        o_valid;
    logic        i_stall;
    logic [3:0]  o_event_res;
    logic [3:0]  o_channel;
    logic [6:0]  o_key_or_controller;
    logic [13:0] o_value;
    logic        no_idle;
    int          mismatch_count;
    int          pending_events;
    int          sent;

    midi_running_status_parser dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_data_byte         (i_data_byte),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_event_res         (o_event_res),
        .o_channel           (o_channel),
        .o_key_or_controller (o_key_or_controller),
        .o_value             (o_value)
    );

    midi_running_status_parser_checker u_checker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_word_valid        (i_valid),
        .i_word_stall        (o_stall),
        .i_data_byte         (i_data_byte),
        .i_event_valid       (o_valid),
        .i_event_stall       (i_stall),
        .i_event_res         (o_event_res),
        .i_channel           (o_channel),
        .i_key_or_controller (o_key_or_controller),
        .i_value             (o_value),
        .o_mismatch_count    (mismatch_count),
        .o_pending           (pending_events)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        if (no_idle) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(0, 99) < 29);
        end
    end

    initial begin
        #3000000;
        $display("status: fail");
        $finish;
    end

    function automatic logic [6:0] rand_data();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
            return 7'h00;
        end
        if (roll < 16) begin
            return 7'h7F;
        end
        return 7'($urandom_range(0, 127));
    endfunction

    task automatic send_word(input logic [7:0] b);
        while (!no_idle && $urandom_range(0, 99) < 29) begin
            i_valid     <= 1'b0;
            i_data_byte <= 8'($urandom);
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        sent++;
        if (sent == 500) begin
            no_idle <= 1'b1;
        end else if (sent == 760) begin
            no_idle <= 1'b0;
        end
    endtask

    initial begin
        logic [7:0]  running;
        logic [6:0]  sx_body [$];
        logic [6:0]  dev;
        int unsigned roll;
        int unsigned n;
        bit          long_done;
        logic [7:0]  opening [$];
        opening = '{
            // master volume first, so every SysEx entry ever read has been written
            mrsp_pkg::BYTE_SYSEX_START, {1'b0, mrsp_pkg::SX_ID_RT},
            {1'b0, mrsp_pkg::SX_DEV_ALL}, {1'b0, mrsp_pkg::SX_SUB_DEV_CTRL},
            {1'b0, mrsp_pkg::SX_MASTER_VOL}, 8'h00, 8'h7F, mrsp_pkg::BYTE_SYSEX_END,
            mrsp_pkg::BYTE_SYSEX_START, {1'b0, mrsp_pkg::SX_ID_NON_RT},
            {1'b0, mrsp_pkg::SX_DEV_ZERO}, {1'b0, mrsp_pkg::SX_SUB_GM},
            {1'b0, mrsp_pkg::SX_GM_OFF}, mrsp_pkg::BYTE_SYSEX_END,
            // note on dropped with GM off, then zero velocity as note off
            {mrsp_pkg::KIND_NOTE_ON, 4'hF}, 8'h7F, 8'h7F, 8'h00, 8'h00,
            mrsp_pkg::BYTE_RT_RESET,
            {mrsp_pkg::KIND_BEND, 4'h0}, 8'h7F, 8'h7F,
            {mrsp_pkg::KIND_CTRL, 4'hA}, 8'h07, mrsp_pkg::BYTE_RT_STOP, 8'h64,
            mrsp_pkg::BYTE_RT_START, mrsp_pkg::BYTE_RT_CONT
        };
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_data_byte <= 8'h00;
        no_idle     <= 1'b0;
        sent        = 0;
        running     = 8'h00;
        long_done   = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (opening[k]) begin
            send_word(opening[k]);
        end

        while (sent < 1450) begin
            roll = $urandom_range(0, 99);
            if (!long_done && sent >= 900) begin
                // long enough to saturate the SysEx length counter
                long_done = 1'b1;
                send_word(mrsp_pkg::BYTE_SYSEX_START);
                repeat (300) send_word({1'b0, rand_data()});
                send_word(mrsp_pkg::BYTE_SYSEX_END);
                running = 8'h00;
            end else if (roll < 50) begin
                if (running == 8'h00 || $urandom_range(0, 99) < 65) begin
                    running = {1'b1, 3'($urandom_range(0, 6)), 4'($urandom)};
                    send_word(running);
                end
                n = (running[7:4] == mrsp_pkg::KIND_PROG ||
                     running[7:4] == mrsp_pkg::KIND_CHAN_PRESS) ? 1 : 2;
                repeat (n) begin
                    if ($urandom_range(0, 19) == 0) begin
                        send_word(8'($urandom_range(mrsp_pkg::BYTE_RT_FIRST, 8'hFE)));
                    end
                    send_word({1'b0, rand_data()});
                end
            end else if (roll < 65) begin
                roll = $urandom_range(0, 99);
                dev = (roll < 45) ? mrsp_pkg::SX_DEV_ZERO :
                      (roll < 90) ? mrsp_pkg::SX_DEV_ALL : 7'($urandom);
                case ($urandom_range(0, 3))
                    0: sx_body = '{mrsp_pkg::SX_ID_NON_RT, dev, mrsp_pkg::SX_SUB_GM,
                                   mrsp_pkg::SX_GM_ON};
                    1: sx_body = '{mrsp_pkg::SX_ID_NON_RT, dev, mrsp_pkg::SX_SUB_GM,
                                   mrsp_pkg::SX_GM_OFF};
                    2: sx_body = '{mrsp_pkg::SX_ID_RT, dev, mrsp_pkg::SX_SUB_DEV_CTRL,
                                   mrsp_pkg::SX_MASTER_VOL, rand_data(), rand_data()};
                    default: begin
                        sx_body = '{($urandom_range(0, 1) ? mrsp_pkg::SX_ID_NON_RT
                                                          : mrsp_pkg::SX_ID_RT), dev,
                                    ($urandom_range(0, 1) ? mrsp_pkg::SX_SUB_GM
                                                          : mrsp_pkg::SX_SUB_DEV_CTRL),
                                    7'($urandom_range(0, 3))};
                        repeat ($urandom_range(0, 3)) sx_body.push_back(rand_data());
                    end
                endcase
                if ($urandom_range(0, 9) == 0) begin
                    sx_body[$urandom_range(0, sx_body.size() - 1)] = 7'($urandom);
                end
                send_word(mrsp_pkg::BYTE_SYSEX_START);
                foreach (sx_body[k]) begin
                    send_word({1'b0, sx_body[k]});
                end
                if ($urandom_range(0, 9) == 0) begin
                    send_word(8'($urandom_range(8'h80, 8'hF6)));
                end else begin
                    send_word(mrsp_pkg::BYTE_SYSEX_END);
                end
                running = 8'h00;
            end else if (roll < 73) begin
                send_word(mrsp_pkg::BYTE_SYSEX_START);
                repeat ($urandom_range(0, 20)) send_word({1'b0, 7'($urandom)});
                send_word(mrsp_pkg::BYTE_SYSEX_END);
                running = 8'h00;
            end else if (roll < 85) begin
                send_word(8'($urandom_range(mrsp_pkg::BYTE_RT_FIRST, mrsp_pkg::BYTE_RT_RESET)));
            end else begin
                send_word(8'($urandom));
                running = 8'h00;
            end
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_events != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
